// ===== hdl/nls_pkg.sv =====
// ----------------------------------------------------------------------------
// Numeric literal scanner package
// Shared types, codes and helper functions for the literal scanner.
// ----------------------------------------------------------------------------
package nls_pkg;

  // Scan phases
  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_DEC      = 3'd1;
  localparam logic [2:0] PH_DEC_EXP0 = 3'd2;
  localparam logic [2:0] PH_DEC_EXP  = 3'd3;
  localparam logic [2:0] PH_RAD      = 3'd4;
  localparam logic [2:0] PH_HEX_FRAC = 3'd5;
  localparam logic [2:0] PH_HEX_EXP0 = 3'd6;
  localparam logic [2:0] PH_HEX_EXP  = 3'd7;

  // Flag bit positions
  localparam int FL_ERR    = 0;
  localparam int FL_MARK   = 1;
  localparam int FL_EXP    = 2;
  localparam int FL_NEG    = 3;
  localparam int FL_EXPDIG = 4;
  localparam int FL_FERR   = 5;

  // Radix codes
  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_HEX = 2'd1;
  localparam logic [1:0] RX_BIN = 2'd2;
  localparam logic [1:0] RX_OCT = 2'd3;

  // Status codes
  localparam logic [2:0] ST_NULL    = 3'd0;
  localparam logic [2:0] ST_FORMAT  = 3'd1;
  localparam logic [2:0] ST_INT     = 3'd2;
  localparam logic [2:0] ST_DOUBLE  = 3'd3;
  localparam logic [2:0] ST_COMPLEX = 3'd4;

  localparam logic [4:0] NO_DIGIT = 5'd16;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LC_E  = 8'h65;
  localparam logic [7:0] CH_UC_E  = 8'h45;
  localparam logic [7:0] CH_LC_P  = 8'h70;
  localparam logic [7:0] CH_UC_P  = 8'h50;
  localparam logic [7:0] CH_LC_J  = 8'h6A;
  localparam logic [7:0] CH_UC_J  = 8'h4A;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_O  = 8'h6F;
  localparam logic [7:0] CH_UC_O  = 8'h4F;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_UC_B  = 8'h42;

  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  radix;
    logic        first_zero;
    logic [1:0]  position;
    logic [63:0] int_acc;
    logic [63:0] frac_acc;
    logic [7:0]  int_count;
    logic [7:0]  frac_count;
    logic [15:0] exp_acc;
    logic [5:0]  flags;
  } nls_state_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [1:0]         radix_kind;
    logic [63:0]        int_value;
    logic [63:0]        frac_value;
    logic [7:0]         frac_digits;
    logic [7:0]         int_digits;
    logic signed [15:0] exponent;
  } nls_result_t;

  localparam nls_state_t STATE_RESET = '{
    phase: PH_START, radix: RX_DEC, first_zero: 1'b0, position: 2'd0,
    int_acc: 64'd0, frac_acc: 64'd0, int_count: 8'd0, frac_count: 8'd0,
    exp_acc: 16'd0, flags: 6'd0
  };

  localparam nls_result_t RESULT_ZERO = '{
    status: ST_NULL, radix_kind: RX_DEC, int_value: 64'd0, frac_value: 64'd0,
    frac_digits: 8'd0, int_digits: 8'd0, exponent: 16'sd0
  };

  function automatic logic is_dec(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Digit value in the radix, NO_DIGIT when the character is not a digit
  function automatic logic [4:0] digit_val(logic [7:0] c, logic [1:0] rx);
    logic [4:0] d;
    d = NO_DIGIT;
    if (is_dec(c)) begin
      d = 5'(c - CH_ZERO);
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      d = 5'(c - 8'h57);
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      d = 5'(c - 8'h37);
    end
    if (rx == RX_BIN && d > 5'd1) d = NO_DIGIT;
    if (rx == RX_OCT && d > 5'd7) d = NO_DIGIT;
    if (rx == RX_DEC && d > 5'd9) d = NO_DIGIT;
    return d;
  endfunction

  function automatic logic [7:0] sat_inc(logic [7:0] n);
    return (n == 8'hFF) ? 8'hFF : n + 8'd1;
  endfunction

  function automatic logic [63:0] mul10_add(logic [63:0] a, logic [3:0] d);
    return (a << 3) + (a << 1) + 64'(d);
  endfunction

  // Exponent magnitude times ten plus digit, saturating at 16 bits
  function automatic logic [15:0] exp_take(logic [15:0] e, logic [3:0] d);
    logic [19:0] m;
    m = ({4'd0, e} << 3) + ({4'd0, e} << 1) + 20'(d);
    return (m > 20'd65535) ? 16'hFFFF : m[15:0];
  endfunction

  // Build the result word from the scan state
  function automatic nls_result_t make_result(nls_state_t s, logic mj);
    nls_result_t r;
    logic [2:0]  st;
    logic [15:0] e;
    if (s.phase[2]) begin
      if (s.radix != RX_HEX || mj || !s.flags[FL_MARK]) begin
        st = (!s.flags[FL_ERR] && s.int_count != 8'd0) ? (mj ? ST_COMPLEX : ST_INT)
                                                       : ST_FORMAT;
      end else begin
        st = (!s.flags[FL_FERR] && s.flags[FL_EXPDIG]) ? ST_DOUBLE : ST_FORMAT;
      end
    end else begin
      if (s.flags[FL_ERR] || (s.flags[FL_EXP] && !s.flags[FL_EXPDIG])) st = ST_NULL;
      else if (mj) st = ST_COMPLEX;
      else if (s.flags[FL_EXP] || s.flags[FL_MARK]) st = ST_DOUBLE;
      else st = ST_INT;
    end
    if (s.exp_acc == 16'd0) e = 16'd0;
    else if (s.flags[FL_NEG]) e = s.exp_acc[15] ? 16'h8000 : 16'(-s.exp_acc);
    else e = s.exp_acc[15] ? 16'h7FFF : s.exp_acc;
    if (st == ST_NULL || st == ST_FORMAT) begin
      r = RESULT_ZERO;
      r.status = st;
    end else begin
      r.status      = st;
      r.radix_kind  = s.radix;
      r.int_value   = s.int_acc;
      r.frac_value  = s.frac_acc;
      r.frac_digits = s.frac_count;
      r.int_digits  = s.int_count;
      r.exponent    = signed'(e);
    end
    return r;
  endfunction

endpackage

// ===== hdl/nls_step.sv =====
// ----------------------------------------------------------------------------
// Numeric literal scanner step
// Next scan state and result word for one character word.
// ----------------------------------------------------------------------------
module nls_step import nls_pkg::*; (
  input  nls_state_t  st_i,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  input  logic        empty_marker_i,
  output nls_state_t  st_o,
  output logic        emit_o,
  output nls_result_t res_o
);

  always_comb begin
    nls_state_t  s;
    logic [7:0]  c;
    logic        mj;
    logic        jlast;
    logic        pfx;
    logic        skip;
    logic [4:0]  d;
    logic        nod;
    logic        us;
    logic        isp;
    logic [63:0] shifted;

    s       = st_i;
    c       = char_code_i;
    mj      = 1'b0;
    skip    = 1'b0;
    emit_o  = 1'b0;
    res_o   = RESULT_ZERO;
    jlast   = last_char_i && (c == CH_LC_J || c == CH_UC_J);
    pfx     = (st_i.position == 2'd1) && st_i.first_zero && (st_i.phase == PH_DEC) &&
              (c == CH_LC_X || c == CH_UC_X || c == CH_LC_O || c == CH_UC_O ||
               c == CH_LC_B || c == CH_UC_B);
    d       = digit_val(c, st_i.radix);
    nod     = (d == NO_DIGIT);
    us      = (c == CH_US);
    isp     = (c == CH_LC_P || c == CH_UC_P);
    case (st_i.radix)
      RX_HEX:  shifted = st_i.int_acc << 4;
      RX_BIN:  shifted = st_i.int_acc << 1;
      default: shifted = st_i.int_acc << 3;
    endcase

    if (empty_marker_i) begin
      if (st_i.position == 2'd0) begin
        emit_o = 1'b1;
        s      = STATE_RESET;
      end else if (last_char_i) begin
        emit_o = 1'b1;
        res_o  = make_result(st_i, 1'b0);
        s      = STATE_RESET;
      end
    end else begin
      if (st_i.phase == PH_START) begin
        s.first_zero = (c == CH_ZERO);
        s.phase      = PH_DEC;
      end
      if (st_i.phase != PH_START && pfx) begin
        // Radix prefix: restart the body in the selected radix
        s.radix     = (c == CH_LC_X || c == CH_UC_X) ? RX_HEX :
                      ((c == CH_LC_B || c == CH_UC_B) ? RX_BIN : RX_OCT);
        s.int_acc   = 64'd0;
        s.int_count = 8'd0;
        s.flags     = 6'd0;
        s.phase     = PH_RAD;
      end else if (st_i.phase[2]) begin
        if (jlast) begin
          mj = 1'b1;
        end else begin
          if (nod && !us) s.flags[FL_ERR] = 1'b1;
          if (s.phase == PH_RAD && !nod) begin
            s.int_acc   = shifted + 64'(d[3:0]);
            s.int_count = sat_inc(s.int_count);
          end
          if (s.radix == RX_HEX) begin
            if (c == CH_DOT || isp) s.flags[FL_MARK] = 1'b1;
            if (!s.flags[FL_FERR]) begin
              case (s.phase)
                PH_RAD: begin
                  if (nod && !us) begin
                    if (c == CH_DOT) begin
                      s.phase = PH_HEX_FRAC;
                    end else if (isp) begin
                      if (s.int_count == 8'd0 && s.frac_count == 8'd0)
                        s.flags[FL_FERR] = 1'b1;
                      else
                        s.phase = PH_HEX_EXP0;
                    end else begin
                      s.flags[FL_FERR] = 1'b1;
                    end
                  end
                end
                PH_HEX_FRAC: begin
                  if (!nod) begin
                    s.frac_acc   = (s.frac_acc << 4) + 64'(d[3:0]);
                    s.frac_count = sat_inc(s.frac_count);
                  end else if (us) begin
                    s.frac_acc = s.frac_acc;
                  end else if (isp) begin
                    if (s.int_count == 8'd0 && s.frac_count == 8'd0)
                      s.flags[FL_FERR] = 1'b1;
                    else
                      s.phase = PH_HEX_EXP0;
                  end else begin
                    s.flags[FL_FERR] = 1'b1;
                  end
                end
                default: begin
                  if (s.phase == PH_HEX_EXP0) begin
                    s.phase = PH_HEX_EXP;
                    if (c == CH_PLUS) begin
                      skip = 1'b1;
                    end else if (c == CH_MINUS) begin
                      s.flags[FL_NEG] = 1'b1;
                      skip            = 1'b1;
                    end
                  end
                  if (!skip) begin
                    if (is_dec(c)) begin
                      s.exp_acc           = exp_take(s.exp_acc, 4'(c - CH_ZERO));
                      s.flags[FL_EXPDIG] = 1'b1;
                    end else if (!us) begin
                      s.flags[FL_FERR] = 1'b1;
                    end
                  end
                end
              endcase
            end
          end
        end
      end else if (!s.flags[FL_ERR]) begin
        // Decimal body
        if (s.phase == PH_DEC) begin
          if (is_dec(c)) begin
            if (s.flags[FL_MARK]) begin
              s.frac_acc   = mul10_add(s.frac_acc, 4'(c - CH_ZERO));
              s.frac_count = sat_inc(s.frac_count);
            end else begin
              s.int_acc   = mul10_add(s.int_acc, 4'(c - CH_ZERO));
              s.int_count = sat_inc(s.int_count);
            end
          end else if (us) begin
            s.flags = s.flags;
          end else if (c == CH_DOT) begin
            if (s.flags[FL_MARK]) s.flags[FL_ERR] = 1'b1;
            else s.flags[FL_MARK] = 1'b1;
          end else if (jlast) begin
            mj = 1'b1;
          end else if (c == CH_LC_E || c == CH_UC_E) begin
            s.flags[FL_EXP] = 1'b1;
            s.phase         = PH_DEC_EXP0;
          end else begin
            s.flags[FL_ERR] = 1'b1;
          end
        end else begin
          if (s.phase == PH_DEC_EXP0) begin
            s.phase = PH_DEC_EXP;
            if (c == CH_PLUS) begin
              skip = 1'b1;
            end else if (c == CH_MINUS) begin
              s.flags[FL_NEG] = 1'b1;
              skip            = 1'b1;
            end
          end
          if (!skip) begin
            if (is_dec(c)) begin
              s.exp_acc           = exp_take(s.exp_acc, 4'(c - CH_ZERO));
              s.flags[FL_EXPDIG] = 1'b1;
            end else if (us) begin
              s.flags = s.flags;
            end else if (jlast) begin
              mj = 1'b1;
            end else begin
              s.flags[FL_ERR] = 1'b1;
            end
          end
        end
      end
      if (s.position != 2'd2) s.position = s.position + 2'd1;
      if (last_char_i) begin
        emit_o = 1'b1;
        res_o  = make_result(s, mj);
        s      = STATE_RESET;
      end
    end
    st_o = s;
  end

endmodule

// ===== hdl/numeric_literal_scanner.sv =====
// ----------------------------------------------------------------------------
// Numeric literal scanner
// Classifies a numeric literal fed one character word at a time.
// ----------------------------------------------------------------------------
// Feed the characters of a literal on the input channel, one word per cycle,
// with last_char_i on the final one. empty_marker_i marks a word with no
// character: with nothing taken yet it yields an all-zero null result, mid
// literal it is dropped unless it is also last. Each literal yields exactly
// one result word on the output channel, on its last word.
// A word is taken when valid is high and stall is low. Words land in an
// input register; the scan state and the result are computed from it
// combinationally (64-bit times-ten add on the decimal accumulators) and
// the result sits in an output register. Throughput is one word per cycle
// while no result word waits on a receiver stall.
// When the receiver stalls, the result is held and the input register keeps
// advancing words that produce no result; a word that would produce a result
// waits, and the input stall rises behind it.
// Reset returns the scanner to the start of a literal with empty registers.
// ----------------------------------------------------------------------------
module numeric_literal_scanner import nls_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  input  logic               last_char_i,
  input  logic               empty_marker_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [1:0]         radix_kind_o,
  output logic [63:0]        int_value_o,
  output logic [63:0]        frac_value_o,
  output logic [7:0]         frac_digits_o,
  output logic [7:0]         int_digits_o,
  output logic signed [15:0] exponent_o
);

  logic        in_vld_q;
  logic [7:0]  char_q;
  logic        last_q;
  logic        empty_q;
  nls_state_t  st_q, st_d;
  logic        emit;
  nls_result_t res_d, res_q;
  logic        out_vld_q;
  logic        adv;
  logic        in_take;

  nls_step u_step (
    .st_i          (st_q),
    .char_code_i   (char_q),
    .last_char_i   (last_q),
    .empty_marker_i(empty_q),
    .st_o          (st_d),
    .emit_o        (emit),
    .res_o         (res_d)
  );

  // Advance the held word unless its result has nowhere to go
  assign adv        = in_vld_q && (!emit || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= STATE_RESET;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        st_q <= st_d;
      end
      if (adv && emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q  <= char_code_i;
      last_q  <= last_char_i;
      empty_q <= empty_marker_i;
    end
    if (adv && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = res_q.status;
  assign radix_kind_o  = res_q.radix_kind;
  assign int_value_o   = res_q.int_value;
  assign frac_value_o  = res_q.frac_value;
  assign frac_digits_o = res_q.frac_digits;
  assign int_digits_o  = res_q.int_digits;
  assign exponent_o    = res_q.exponent;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (res_q.status == ST_NULL || res_q.status == ST_FORMAT) |->
      res_q.int_value == 64'd0 && res_q.frac_value == 64'd0 &&
      res_q.exponent == 16'sd0 && res_q.int_digits == 8'd0)
    else $error("error result carries nonzero fields");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> res_q.status <= ST_COMPLEX)
    else $error("status code out of range");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && emit |=> st_q.phase == PH_START && st_q.position == 2'd0)
    else $error("scanner not restarted after result");

  a_pos_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.position == 2'd0 |-> st_q.phase == PH_START)
    else $error("phase advanced with no character taken");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(char_q) && $stable(last_q))
    else $error("held input word lost");

endmodule
